@@ rtl/rsf_pkg.sv @@
package rsf_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_FIXUP   = 3'd0,
      ST_ADVANCE = 3'd1,
      ST_END     = 3'd2,
      ST_ERROR   = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   // Input item kinds
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_BYTE  = 1'b1;

   // Register indexes of the configuration port
   localparam logic CSR_TEXT_BASE   = 1'b0;
   localparam logic CSR_SEGMENT_LEN = 1'b1;

   localparam int ADDR_W = 32;
   localparam int SEG_W  = 31;

   // Relocation byte codes and the skip distance
   localparam logic [7:0] BYTE_END  = 8'h00;
   localparam logic [7:0] BYTE_SKIP = 8'h01;
   localparam logic [7:0] SKIP_STEP = 8'hfe;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] fixup_address;
   } result_type;

endpackage

@@ rtl/rsf_core.sv @@
module rsf_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic                      csr_index,
   input  logic [31:0]               csr_wdata,
   input  logic                      item_fire,
   input  logic                      item_mode,
   input  logic [31:0]               item_value,
   output rsf_pkg::result_type       result
);
   import rsf_pkg::*;

   logic [ADDR_W-1:0] text_base_ff, text_base_in;
   logic [SEG_W-1:0]  seg_len_ff, seg_len_in;
   logic [ADDR_W-1:0] offset_ff, offset_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              active_ff, active_in;

   logic [7:0]        rel_byte;
   logic [7:0]        step;
   logic [ADDR_W:0]   off_sum;
   logic [ADDR_W-1:0] off_sat;
   logic [ADDR_W-1:0] addr_step;
   logic [ADDR_W-1:0] addr_start;
   logic              start_bad;
   logic              byte_bad;

   // Shared datapath: one saturating add and compare on the offset,
   // with the absolute address tracked beside it
   always_comb begin
      rel_byte   = item_value[7:0];
      step       = (rel_byte == BYTE_SKIP) ? SKIP_STEP : rel_byte;
      off_sum    = {1'b0, offset_ff} + {{(ADDR_W-7){1'b0}}, step};
      off_sat    = off_sum[ADDR_W] ? '1 : off_sum[ADDR_W-1:0];
      addr_step  = addr_ff + {{(ADDR_W-8){1'b0}}, step};
      addr_start = text_base_ff + item_value;
      start_bad  = item_value[31] || (item_value >= {1'b0, seg_len_ff});
      byte_bad   = off_sat >= {1'b0, seg_len_ff};
   end

   // Decode one item and the state it leaves
   always_comb begin
      result.status        = ST_IGNORED;
      result.fixup_address = '0;
      offset_in            = offset_ff;
      addr_in              = addr_ff;
      active_in            = active_ff;
      if (item_mode == MODE_START) begin
         if (item_value == '0) begin
            result.status = ST_END;
            active_in     = 1'b0;
         end else if (start_bad) begin
            result.status = ST_ERROR;
            active_in     = 1'b0;
         end else begin
            result.status        = ST_FIXUP;
            result.fixup_address = addr_start;
            offset_in            = item_value;
            addr_in              = addr_start;
            active_in            = 1'b1;
         end
      end else if (active_ff) begin
         if (rel_byte == BYTE_END) begin
            result.status = ST_END;
            active_in     = 1'b0;
         end else if (rel_byte == BYTE_SKIP) begin
            result.status = ST_ADVANCE;
            offset_in     = off_sat;
            addr_in       = addr_step;
         end else if (byte_bad) begin
            result.status = ST_ERROR;
            offset_in     = off_sat;
            active_in     = 1'b0;
         end else begin
            result.status        = ST_FIXUP;
            result.fixup_address = addr_step;
            offset_in            = off_sat;
            addr_in              = addr_step;
         end
      end
   end

   // Configuration writes; a new base re-aims the tracked address
   always_comb begin
      text_base_in = text_base_ff;
      seg_len_in   = seg_len_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_TEXT_BASE:   text_base_in = csr_wdata;
            CSR_SEGMENT_LEN: seg_len_in   = csr_wdata[SEG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_base_ff <= '0;
         seg_len_ff   <= '0;
         offset_ff    <= '0;
         addr_ff      <= '0;
         active_ff    <= 1'b0;
      end else begin
         text_base_ff <= text_base_in;
         seg_len_ff   <= seg_len_in;
         active_ff    <= item_fire ? active_in : active_ff;
         offset_ff    <= item_fire ? offset_in : offset_ff;
         if (item_fire) begin
            addr_ff <= addr_in;
         end else if (csr_wen && csr_index == CSR_TEXT_BASE) begin
            addr_ff <= csr_wdata + offset_ff;
         end
      end
   end

endmodule

@@ rtl/relocation_stream_fixup.sv @@
// Relocation list decoder: takes a program's relocation stream one beat at a
// time (a start beat carrying the first 32-bit offset, then one relocation
// byte per beat) and returns exactly one result beat per input beat, giving
// a status and, for a fixup, the address of the longword that needs the
// text base added. Throughput is one beat per clock while rsp_tready stays
// high. Each accepted beat is held in the input register, passes through a
// single add-and-compare on the running offset, and is held in the result
// register until taken. Write text_base and segment_length only while the
// block holds no unfinished beat.
module relocation_stream_fixup (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] fixup_address
   output logic [2:0]  rsp_tuser    // [2:0] status
);
   import rsf_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [31:0] in_value_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff;
   result_type  core_res;
   logic        advance;
   logic        req_fire;

   // Move the held beat forward when the result register is free or its beat is being taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   rsf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_fire  (advance),
      .item_mode  (in_mode_ff),
      .item_value (in_value_ff),
      .result     (core_res)
   );

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: capture input beat, hold result until taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff  <= req_tuser[0];
         in_value_ff <= req_tdata;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.fixup_address;
   assign rsp_tuser  = out_res_ff.status;

endmodule

@@ rtl/rsf_checker.sv @@
module rsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import rsf_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Address is zero unless a fixup is reported
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FIXUP |-> rsp_tdata == '0)
      else $error("nonzero address on a non-fixup result");

   // With the result side empty the input side is always open
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   // Reset drops any result beat
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind relocation_stream_fixup rsf_checker u_rsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ bench/relocation_checker.sv @@
`timescale 1ns / 100ps

// Watches the request, response and register ports of the relocation decoder,
// predicts each response beat from the request beats it has seen, and compares.
module relocation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] fixup_address
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   output int          mismatches,
   output int          outstanding
);
   import rsf_pkg::*;

   // Shadow registers and decoder state
   logic [ADDR_W-1:0] load_base;
   logic [SEG_W-1:0]  seg_limit;
   logic [31:0]       cur_offset;
   logic              list_open;
   result_type        pending_fixups[$];

   // Decode one request beat against the shadow state and advance that state
   function automatic result_type decode_beat(input logic mode, input logic [31:0] value);
      result_type  res;
      logic [32:0] sum;
      logic [7:0]  rel_byte;
      res.status        = ST_IGNORED;
      res.fixup_address = '0;
      rel_byte          = value[7:0];
      if (mode == MODE_START) begin
         if (value == 32'd0) begin
            list_open  = 1'b0;
            res.status = ST_END;
         end else if (value[31] || value >= {1'b0, seg_limit}) begin
            list_open  = 1'b0;
            res.status = ST_ERROR;
         end else begin
            cur_offset        = value;
            list_open         = 1'b1;
            res.status        = ST_FIXUP;
            res.fixup_address = load_base + cur_offset;
         end
      end else if (list_open) begin
         if (rel_byte == BYTE_END) begin
            list_open  = 1'b0;
            res.status = ST_END;
         end else begin
            // saturate the running offset at all ones
            sum = {1'b0, cur_offset} +
                  {25'd0, (rel_byte == BYTE_SKIP) ? SKIP_STEP : rel_byte};
            cur_offset = sum[32] ? 32'hffff_ffff : sum[31:0];
            if (rel_byte == BYTE_SKIP) begin
               res.status = ST_ADVANCE;
            end else if (cur_offset >= {1'b0, seg_limit}) begin
               list_open  = 1'b0;
               res.status = ST_ERROR;
            end else begin
               res.status        = ST_FIXUP;
               res.fixup_address = load_base + cur_offset;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         load_base  = '0;
         seg_limit  = '0;
         cur_offset = '0;
         list_open  = 1'b0;
         mismatches = 0;
         pending_fixups.delete();
      end else begin
         // track register writes
         if (csr_wen) begin
            if (csr_index == CSR_TEXT_BASE) load_base = csr_wdata;
            else seg_limit = csr_wdata[SEG_W-1:0];
         end

         // compare the response beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (pending_fixups.size() == 0) begin
               $display("%0t: unexpected response beat status %0d address %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_fixups.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata !== want.fixup_address) begin
                  $display("%0t: fixup_address expected %h got %h",
                           $time, want.fixup_address, rsp_tdata);
                  mismatches++;
               end
            end
         end

         // predict the response of each accepted request beat
         if (req_tvalid && req_tready)
            pending_fixups.push_back(decode_beat(req_tuser[0], req_tdata));
      end
      outstanding = pending_fixups.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import rsf_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic        csr_index;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic [0:0]  req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] fixup_address
   logic [2:0]  rsp_tuser;   // [2:0] status

   int          mismatches;
   int          outstanding;
   int          beats_sent;
   int unsigned seg_setting;
   logic        quiet_sender;
   logic        quiet_sink;

   relocation_stream_fixup dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   relocation_checker fixup_watch (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Stall the response side at random
   initial begin
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         hold = quiet_sink ? 0 : pick_gap();
         if (hold > 0) begin
            rsp_tready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   // Present one request beat and hold it until accepted
   task automatic send_beat(input logic mode, input logic [31:0] value);
      int gap;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      beats_sent++;
   endtask

   // Wait until every response is back and the pipeline is empty
   task automatic drain();
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] data);
      drain();
      csr_wen   = 1'b1;
      csr_index = index;
      csr_wdata = data;
      if (index == CSR_SEGMENT_LEN) seg_setting = {1'b0, data[SEG_W-1:0]};
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // One relocation list: a start beat, a run of bytes, maybe an end byte
   task automatic run_list();
      int          roll;
      int          count;
      logic [31:0] first;
      logic [23:0] upper;
      logic [7:0]  rel_byte;
      roll = $urandom_range(0, 99);
      if (roll < 80 && seg_setting > 1) first = $urandom_range(1, seg_setting - 1);
      else if (roll < 86) first = 32'd0;
      else if (roll < 93) first = $urandom | 32'h8000_0000;
      else first = $urandom;
      send_beat(MODE_START, first);

      count = $urandom_range(0, 30);
      repeat (count) begin
         roll     = $urandom_range(0, 99);
         upper    = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'd0;
         if (roll < 2) rel_byte = BYTE_END;
         else if (roll < 16) rel_byte = BYTE_SKIP;
         else if (roll < 50) rel_byte = 8'($urandom_range(2, 8));
         else rel_byte = 8'($urandom_range(2, 255));
         send_beat(MODE_BYTE, {upper, rel_byte});
         // hold off now and then until every response is back
         if ($urandom_range(0, 199) == 0) drain();
      end

      roll = $urandom_range(0, 99);
      if (roll < 60) send_beat(MODE_BYTE, {($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'd0,
                                           BYTE_END});
      // now and then a stray byte after the list
      if (roll >= 90) send_beat(MODE_BYTE, $urandom);
   endtask

   initial begin
      int          phase_end;
      int          roll;
      logic [31:0] base;
      logic [31:0] seg;
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_index    = CSR_TEXT_BASE;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = MODE_START;
      quiet_sender = 1'b0;
      quiet_sink   = 1'b0;
      beats_sent   = 0;
      seg_setting  = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed: byte before any start, start codes, byte codes, limits
      write_reg(CSR_TEXT_BASE, 32'h1000_0000);
      write_reg(CSR_SEGMENT_LEN, 32'h0000_1000);
      send_beat(MODE_BYTE, 32'd5);
      send_beat(MODE_START, 32'd0);
      send_beat(MODE_START, 32'h8000_0000);
      send_beat(MODE_START, 32'hffff_ffff);
      send_beat(MODE_START, 32'h0000_1000);
      send_beat(MODE_START, 32'd2);
      send_beat(MODE_BYTE, {24'd0, BYTE_SKIP});
      send_beat(MODE_BYTE, 32'd4);
      send_beat(MODE_BYTE, 32'h0000_0105);
      send_beat(MODE_BYTE, 32'hffff_ff02);
      send_beat(MODE_BYTE, 32'h0000_00ff);
      send_beat(MODE_BYTE, {24'd0, BYTE_END});
      send_beat(MODE_BYTE, 32'd7);
      // restart while a list is open, then skip past the segment end
      send_beat(MODE_START, 32'h0000_0010);
      send_beat(MODE_START, 32'h0000_0ffe);
      send_beat(MODE_BYTE, {24'd0, BYTE_SKIP});
      send_beat(MODE_BYTE, 32'd2);
      send_beat(MODE_BYTE, 32'd3);
      send_beat(MODE_START, 32'h0000_0fff);
      send_beat(MODE_BYTE, {24'hffffff, BYTE_END});
      // largest base and segment, address wraps
      write_reg(CSR_TEXT_BASE, 32'hffff_ffff);
      write_reg(CSR_SEGMENT_LEN, 32'hffff_ffff);
      send_beat(MODE_START, 32'h7fff_fffe);
      send_beat(MODE_BYTE, 32'd2);
      send_beat(MODE_START, 32'h7fff_ffff);
      // empty segment
      write_reg(CSR_TEXT_BASE, 32'd0);
      write_reg(CSR_SEGMENT_LEN, 32'd0);
      send_beat(MODE_START, 32'd1);
      send_beat(MODE_BYTE, 32'd2);

      // Random phases, each with its own register setting and idling mix
      while (beats_sent < 1400) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) base = 32'd0;
         else if (roll == 1) base = 32'hffff_ffff;
         else base = $urandom;
         roll = $urandom_range(0, 9);
         if (roll == 0) seg = 32'd1;
         else if (roll == 1) seg = 32'h7fff_ffff;
         else if (roll < 6) seg = $urandom_range(16, 4096);
         else seg = $urandom;
         write_reg(CSR_TEXT_BASE, base);
         write_reg(CSR_SEGMENT_LEN, seg);
         quiet_sender = ($urandom_range(0, 3) == 0);
         quiet_sink   = ($urandom_range(0, 3) == 0);
         phase_end    = beats_sent + $urandom_range(100, 200);
         while (beats_sent < phase_end) run_list();
      end
      quiet_sender = 1'b0;
      quiet_sink   = 1'b0;

      // Let the last responses come back, then a few more cycles
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ relocation_stream_fixup.f @@
rtl/rsf_pkg.sv
rtl/rsf_core.sv
rtl/relocation_stream_fixup.sv
rtl/rsf_checker.sv
bench/relocation_checker.sv
bench/testbench.sv
